// File: rtl/core/sntp_ros_pkg.sv
`timescale 1ns / 1ps

package sntp_ros_pkg;

    localparam int SLOT_W     = 3;
    localparam int MAX_SLOTS  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STAMP_W    = 64;

    localparam logic [15:0] MIN_PACKET_LENGTH = 16'd48;
    localparam logic [7:0]  UNSYNC_STRATUM    = 8'd16;
    localparam logic [1:0]  LEAP_ALARM        = 2'd3;
    localparam logic [2:0]  VERSION_MIN       = 3'd1;
    localparam logic [2:0]  VERSION_MAX       = 3'd3;
    localparam logic [2:0]  PKT_MODE_SRV      = 3'd4;
    localparam logic [2:0]  PKT_MODE_BCAST    = 3'd5;

    localparam logic [31:0] DEAD_TIMEOUT_RESET = 32'd3600;
    localparam logic [30:0] MAX_SLEW_RESET     = 31'h1000_0000;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [2:0] {
        ACT_DROP         = 3'd0,
        ACT_UNSYNC       = 3'd1,
        ACT_NOT_SELECTED = 3'd2,
        ACT_SLEW         = 3'd3,
        ACT_STEP         = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BROADCAST_ENABLE = 2'd0,
        CFG_CONFIGURED_MASK  = 2'd1,
        CFG_DEAD_TIMEOUT     = 2'd2,
        CFG_MAX_SLEW         = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLS_DROP   = 2'd0,
        CLS_LEAP   = 2'd1,
        CLS_ACCEPT = 2'd2
    } pkt_class_t;

    typedef struct packed {
        logic  load_in;
        logic  commit;
        logic  rd_en;
        logic  rd_cur;
        slot_t rd_idx;
        logic  eval_cur;
        logic  best_clear;
        logic  scan_eval;
        logic  sel_update;
        logic  load_out;
    } ros_cmd_t;

    typedef struct packed {
        logic       pkt_valid;
        pkt_class_t cls;
        logic       out_busy;
    } ros_status_t;

    // A server is better when its stratum is lower, or equal and it alone is configured.
    function automatic logic better(input logic [7:0] sa, input logic ca,
                                    input logic [7:0] sb, input logic cb);
        logic res;
        if (sa < sb)
        begin
            res = 1'b1;
        end
        else if (sa == sb)
        begin
            res = ca && !cb;
        end
        else
        begin
            res = 1'b0;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/sntp_ros_pkt_if.sv
`timescale 1ns / 1ps

interface sntp_ros_pkt_if;
    import sntp_ros_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  server_slot;
    logic [15:0]        packet_length;
    logic [7:0]         leap_version_mode;
    logic [7:0]         peer_stratum;
    logic [STAMP_W-1:0] origin_stamp;
    logic [STAMP_W-1:0] receive_stamp;
    logic [STAMP_W-1:0] transmit_stamp;
    logic [STAMP_W-1:0] arrival_stamp;

    modport source (
        output valid, server_slot, packet_length, leap_version_mode, peer_stratum,
               origin_stamp, receive_stamp, transmit_stamp, arrival_stamp,
        input  ready
    );

    modport sink (
        input  valid, server_slot, packet_length, leap_version_mode, peer_stratum,
               origin_stamp, receive_stamp, transmit_stamp, arrival_stamp,
        output ready
    );
endinterface

// File: rtl/core/sntp_ros_res_if.sv
`timescale 1ns / 1ps

interface sntp_ros_res_if;
    import sntp_ros_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [2:0]                action;
    logic signed [31:0]        slew_fraction;
    logic [STAMP_W-1:0]        step_time;
    logic signed [STAMP_W-1:0] clock_offset;
    logic [SLOT_W-1:0]         selected_slot;
    logic                      selected_valid;

    modport source (
        output valid, action, slew_fraction, step_time, clock_offset,
               selected_slot, selected_valid,
        input  ready
    );

    modport sink (
        input  valid, action, slew_fraction, step_time, clock_offset,
               selected_slot, selected_valid,
        output ready
    );
endinterface

// File: rtl/core/sntp_ros_cfg_if.sv
`timescale 1ns / 1ps

interface sntp_ros_cfg_if;
    import sntp_ros_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/core/sntp_ros_ctl.sv
`timescale 1ns / 1ps

module sntp_ros_ctl #(
    parameter int SERVER_SLOTS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sntp_ros_pkg::ros_status_t status,
    output sntp_ros_pkg::ros_cmd_t    cmd
);
    import sntp_ros_pkg::*;

    localparam int NSLOT = (SERVER_SLOTS < MAX_SLOTS) ? SERVER_SLOTS : MAX_SLOTS;
    localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NSLOT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_CUR,
        ST_EV_CUR,
        ST_SCAN,
        ST_SEL,
        ST_OUT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = 1'b1;
                if (status.pkt_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.commit = 1'b1;
                state_next = (status.cls == CLS_ACCEPT) ? ST_RD_CUR : ST_OUT;
            end
            ST_RD_CUR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_cur = 1'b1;
                state_next = ST_EV_CUR;
            end
            ST_EV_CUR:
            begin
                cmd.eval_cur   = 1'b1;
                cmd.best_clear = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_idx     = '0;
                cnt_next       = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_eval = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_SEL;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = SLOT_W'(cnt_reg + IDX_W'(1));
                    cnt_next   = cnt_reg + IDX_W'(1);
                end
            end
            ST_SEL:
            begin
                cmd.sel_update = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/core/sntp_ros_dp.sv
`timescale 1ns / 1ps

module sntp_ros_dp #(
    parameter int SERVER_SLOTS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    sntp_ros_pkt_if.sink              pkt,
    sntp_ros_res_if.source            res,
    sntp_ros_cfg_if.sink              cfg,
    input  sntp_ros_pkg::ros_cmd_t    cmd,
    output sntp_ros_pkg::ros_status_t status
);
    import sntp_ros_pkg::*;

    localparam int NSLOT = (SERVER_SLOTS < MAX_SLOTS) ? SERVER_SLOTS : MAX_SLOTS;
    localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam logic [SLOT_W:0] NSLOT_CODE = (SLOT_W + 1)'(NSLOT);

    // Configuration registers.
    logic        bcast_en_reg;
    logic [7:0]  cfg_mask_reg;
    logic [31:0] dead_timeout_reg;
    logic [30:0] max_slew_reg;

    // Captured input item.
    slot_t              slot_reg;
    logic [15:0]        len_reg;
    logic [7:0]         lvm_reg;
    logic [7:0]         stratum_in_reg;
    logic [STAMP_W-1:0] org_reg;
    logic [STAMP_W-1:0] rec_reg;
    logic [STAMP_W-1:0] xmt_reg;
    logic [STAMP_W-1:0] arr_reg;

    // Per-server tables.
    logic [7:0]       stratum_mem [NSLOT];
    logic [31:0]      second_mem  [NSLOT];
    logic [NSLOT-1:0] heard_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [7:0]       rd_stratum_reg;
    logic [31:0]      rd_second_reg;
    logic             rd_heard_reg;

    // Selection state.
    slot_t            cur_slot_reg;
    logic             cur_valid_reg;
    logic [7:0]       cur_stratum_reg;
    logic             cur_cfg_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [7:0]       best_stratum_reg;
    logic             best_cfg_reg;
    logic             have_best_reg;

    // Offset pipeline.
    logic [STAMP_W-1:0] diff_ro_reg;
    logic [STAMP_W-1:0] diff_xa_reg;
    logic [STAMP_W-1:0] offset_reg;
    logic [STAMP_W-1:0] offset_next;
    logic               slew_ok_reg;
    logic [STAMP_W-1:0] max_ext;
    logic [STAMP_W-1:0] neg_max;

    // Result register.
    logic                out_valid_reg;
    action_t             action_reg;
    logic [31:0]         slew_reg;
    logic [STAMP_W-1:0]  step_reg;
    logic [STAMP_W-1:0]  offset_out_reg;
    slot_t               sel_slot_reg;
    logic                sel_valid_reg;
    action_t             action_next;

    logic [1:0]       leap;
    logic [2:0]       version;
    logic [2:0]       mode;
    logic             slot_in_range;
    logic             mode_ok;
    logic             unicast;
    pkt_class_t       cls;
    logic [IDX_W-1:0] slot_idx;
    logic [31:0]      now_sec;
    logic [31:0]      rd_age;
    logic             rd_live;
    logic             rd_cfg;
    logic             selected;

    assign pkt.ready = cmd.load_in;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcast_en_reg     <= 1'b0;
            cfg_mask_reg     <= '0;
            dead_timeout_reg <= DEAD_TIMEOUT_RESET;
            max_slew_reg     <= MAX_SLEW_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_BROADCAST_ENABLE: bcast_en_reg     <= cfg.data[0];
                CFG_CONFIGURED_MASK:  cfg_mask_reg     <= cfg.data[7:0];
                CFG_DEAD_TIMEOUT:     dead_timeout_reg <= cfg.data;
                CFG_MAX_SLEW:         max_slew_reg     <= cfg.data[30:0];
                default:              bcast_en_reg     <= bcast_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            slot_reg       <= pkt.server_slot;
            len_reg        <= pkt.packet_length;
            lvm_reg        <= pkt.leap_version_mode;
            stratum_in_reg <= pkt.peer_stratum;
            org_reg        <= pkt.origin_stamp;
            rec_reg        <= pkt.receive_stamp;
            xmt_reg        <= pkt.transmit_stamp;
            arr_reg        <= pkt.arrival_stamp;
        end
    end

    assign leap          = lvm_reg[7:6];
    assign version       = lvm_reg[5:3];
    assign mode          = lvm_reg[2:0];
    assign slot_in_range = ({1'b0, slot_reg} < NSLOT_CODE);
    assign mode_ok       = (mode == PKT_MODE_SRV) || ((mode == PKT_MODE_BCAST) && bcast_en_reg);
    assign slot_idx      = slot_reg[IDX_W-1:0];
    assign now_sec       = arr_reg[63:32];

    always_comb
    begin
        if (!slot_in_range || (len_reg < MIN_PACKET_LENGTH) ||
            (version < VERSION_MIN) || (version > VERSION_MAX))
        begin
            cls = CLS_DROP;
        end
        else if (leap == LEAP_ALARM)
        begin
            cls = CLS_LEAP;
        end
        else if (!mode_ok || (xmt_reg[63:32] == 32'd0))
        begin
            cls = CLS_DROP;
        end
        else
        begin
            cls = CLS_ACCEPT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                stratum_mem[i] <= '0;
            end
            heard_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (cls == CLS_LEAP)
            begin
                stratum_mem[slot_idx] <= UNSYNC_STRATUM;
            end
            else if (cls == CLS_ACCEPT)
            begin
                stratum_mem[slot_idx] <= stratum_in_reg;
                heard_reg[slot_idx]   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (cls == CLS_ACCEPT))
        begin
            second_mem[slot_idx] <= now_sec;
        end
    end

    assign rd_addr = cmd.rd_cur ? cur_slot_reg[IDX_W-1:0] : cmd.rd_idx[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_idx_reg     <= rd_addr;
            rd_stratum_reg <= stratum_mem[rd_addr];
            rd_second_reg  <= second_mem[rd_addr];
            rd_heard_reg   <= heard_reg[rd_addr];
        end
    end

    assign rd_age  = now_sec - rd_second_reg;
    assign rd_live = rd_heard_reg && !(rd_age > dead_timeout_reg);
    assign rd_cfg  = cfg_mask_reg[rd_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg     <= '0;
            cur_valid_reg    <= 1'b0;
            cur_stratum_reg  <= '0;
            cur_cfg_reg      <= 1'b0;
            best_idx_reg     <= '0;
            best_stratum_reg <= '0;
            best_cfg_reg     <= 1'b0;
            have_best_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.eval_cur)
            begin
                cur_stratum_reg <= rd_stratum_reg;
                cur_cfg_reg     <= rd_cfg;
                if (!rd_live)
                begin
                    cur_valid_reg <= 1'b0;
                end
            end
            if (cmd.best_clear)
            begin
                have_best_reg <= 1'b0;
            end
            if (cmd.scan_eval && rd_live &&
                (!have_best_reg ||
                 better(rd_stratum_reg, rd_cfg, best_stratum_reg, best_cfg_reg)))
            begin
                have_best_reg    <= 1'b1;
                best_idx_reg     <= rd_idx_reg;
                best_stratum_reg <= rd_stratum_reg;
                best_cfg_reg     <= rd_cfg;
            end
            if (cmd.sel_update && have_best_reg &&
                (!cur_valid_reg ||
                 better(best_stratum_reg, best_cfg_reg, cur_stratum_reg, cur_cfg_reg)))
            begin
                cur_slot_reg  <= SLOT_W'(best_idx_reg);
                cur_valid_reg <= 1'b1;
            end
        end
    end

    assign unicast = (mode == PKT_MODE_SRV) && (org_reg[63:32] != 32'd0) &&
                     (rec_reg[63:32] != 32'd0);
    assign offset_next = unicast ?
                         ({diff_ro_reg[63], diff_ro_reg[63:1]} +
                          {diff_xa_reg[63], diff_xa_reg[63:1]}) :
                         diff_xa_reg;
    assign max_ext = {33'd0, max_slew_reg};
    assign neg_max = 64'd0 - max_ext;

    always_ff @(posedge clk)
    begin
        diff_ro_reg <= rec_reg - org_reg;
        diff_xa_reg <= xmt_reg - arr_reg;
        offset_reg  <= offset_next;
        slew_ok_reg <= ($signed(offset_reg) < $signed(max_ext)) &&
                       ($signed(offset_reg) > $signed(neg_max));
    end

    assign selected = cur_valid_reg && (cur_slot_reg == slot_reg);

    always_comb
    begin
        case (cls)
            CLS_LEAP:
            begin
                action_next = ACT_UNSYNC;
            end
            CLS_ACCEPT:
            begin
                if (!selected)
                begin
                    action_next = ACT_NOT_SELECTED;
                end
                else if (slew_ok_reg)
                begin
                    action_next = ACT_SLEW;
                end
                else
                begin
                    action_next = ACT_STEP;
                end
            end
            default:
            begin
                action_next = ACT_DROP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            action_reg     <= action_next;
            slew_reg       <= (action_next == ACT_SLEW) ? offset_reg[31:0] : 32'd0;
            step_reg       <= (action_next == ACT_STEP) ? xmt_reg : '0;
            offset_out_reg <= ((action_next == ACT_SLEW) || (action_next == ACT_STEP)) ?
                              offset_reg : '0;
            sel_slot_reg   <= cur_slot_reg;
            sel_valid_reg  <= cur_valid_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.action         = action_reg;
    assign res.slew_fraction  = $signed(slew_reg);
    assign res.step_time      = step_reg;
    assign res.clock_offset   = $signed(offset_out_reg);
    assign res.selected_slot  = sel_slot_reg;
    assign res.selected_valid = sel_valid_reg;

    assign status.pkt_valid = pkt.valid;
    assign status.cls       = cls;
    assign status.out_busy  = out_valid_reg && !res.ready;

endmodule

// File: rtl/core/sntp_reply_offset_and_select.sv
// A dropped or unsynchronized item goes from ST_CHECK to ST_OUT; an accepted packet passes
// ST_RD_CUR, ST_EV_CUR, a one-slot-per-cycle scan of N slots, ST_SEL and ST_OUT, where N
// is SERVER_SLOTS capped at 8 slots. A new item is taken only once back in ST_IDLE.
// Reset: rst_n clears strata, heard flags, selection, and the configuration to defaults.
`timescale 1ns / 1ps

module sntp_reply_offset_and_select #(
    parameter int SERVER_SLOTS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    sntp_ros_pkt_if.sink   pkt,
    sntp_ros_res_if.source res,
    sntp_ros_cfg_if.sink   cfg
);
    import sntp_ros_pkg::*;

    ros_cmd_t    cmd;
    ros_status_t status;

    sntp_ros_ctl #(
        .SERVER_SLOTS (SERVER_SLOTS)
    ) u_ctl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sntp_ros_dp #(
        .SERVER_SLOTS (SERVER_SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt),
        .res    (res),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sntp_ros_pkg::*;

    localparam int SLOTS = 8;
    localparam int PHASE_ITEMS = 113;
    localparam int BACKLOG_CYCLES = 300;

    localparam logic [1:0] LEAP_NONE  = 2'd0;
    localparam logic [1:0] LEAP_MINUS = 2'd2;
    localparam logic [2:0] PKT_MODE_CLI = 3'd3;
    localparam logic [2:0] VERSION_ZERO = 3'd0;
    localparam logic [2:0] VERSION_FOUR = 3'd4;

    localparam logic [63:0] T0 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_SEC = 64'h1_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        slot_t       slot;
        logic [15:0] length;
        logic [7:0]  lvm;
        logic [7:0]  stratum;
        logic [63:0] origin;
        logic [63:0] receive;
        logic [63:0] transmit;
        logic [63:0] arrival;
    } ntp_pkt_t;

    typedef struct {
        action_t     action;
        logic [31:0] slew_fraction;
        logic [63:0] step_time;
        logic [63:0] clock_offset;
        slot_t       selected_slot;
        logic        selected_valid;
    } sync_result_t;

    typedef struct {
        ntp_pkt_t     p;
        bit           typed;
        sync_result_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sntp_ros_pkt_if pkt_bus ();
    sntp_ros_res_if res_bus ();
    sntp_ros_cfg_if cfg_bus ();

    sntp_reply_offset_and_select #(
        .SERVER_SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pkt(pkt_bus),
        .res(res_bus),
        .cfg(cfg_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Local copy of the block's configuration and server table.
    logic        bcast_en = 1'b0;
    logic [7:0]  cfg_mask = 8'd0;
    logic [31:0] dead_timeout = DEAD_TIMEOUT_RESET;
    logic [30:0] max_slew = MAX_SLEW_RESET;

    logic [7:0]  srv_stratum [SLOTS];
    logic        srv_heard [SLOTS];
    logic [31:0] srv_reply_sec [SLOTS];
    slot_t       sel_slot = '0;
    logic        sel_valid = 1'b0;

    sync_result_t sync_expect_q [$];
    sync_result_t head;
    int mismatch_count = 0;
    int results_seen = 0;
    bit calm = 1'b0;
    logic [31:0] wall_sec;

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            srv_stratum[s] = 8'd0;
            srv_heard[s] = 1'b0;
            srv_reply_sec[s] = 32'd0;
        end
    end

    function automatic logic slot_stale(input slot_t s, input logic [31:0] now);
        logic [31:0] age;
        age = now - srv_reply_sec[s];
        return age > dead_timeout;
    endfunction

    function automatic logic slot_better(input slot_t a, input slot_t b);
        if (srv_stratum[a] != srv_stratum[b])
        begin
            return srv_stratum[a] < srv_stratum[b];
        end
        return cfg_mask[a] && !cfg_mask[b];
    endfunction

    function automatic sync_result_t predict_sync(input ntp_pkt_t p);
        sync_result_t r;
        logic [1:0]  leap;
        logic [2:0]  ver;
        logic [2:0]  mode;
        logic [31:0] now;
        slot_t       best;
        logic        have_best;
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] offset;
        longint      so;
        longint      lim;
        leap = p.lvm[7:6];
        ver = p.lvm[5:3];
        mode = p.lvm[2:0];
        now = p.arrival[63:32];
        r.action = ACT_DROP;
        r.slew_fraction = '0;
        r.step_time = '0;
        r.clock_offset = '0;
        if (p.length < MIN_PACKET_LENGTH || ver < VERSION_MIN || ver > VERSION_MAX)
        begin
            r.action = ACT_DROP;
        end
        else if (leap == LEAP_ALARM)
        begin
            srv_stratum[p.slot] = UNSYNC_STRATUM;
            r.action = ACT_UNSYNC;
        end
        else if (!(mode == PKT_MODE_SRV || (mode == PKT_MODE_BCAST && bcast_en))
                 || p.transmit[63:32] == 32'd0)
        begin
            r.action = ACT_DROP;
        end
        else
        begin
            srv_stratum[p.slot] = p.stratum;
            srv_reply_sec[p.slot] = now;
            srv_heard[p.slot] = 1'b1;
            if (sel_valid && (!srv_heard[sel_slot] || slot_stale(sel_slot, now)))
            begin
                sel_valid = 1'b0;
            end
            have_best = 1'b0;
            best = '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                if (srv_heard[s] && !slot_stale(slot_t'(s), now))
                begin
                    if (!have_best || slot_better(slot_t'(s), best))
                    begin
                        best = slot_t'(s);
                        have_best = 1'b1;
                    end
                end
            end
            if (have_best && (!sel_valid || slot_better(best, sel_slot)))
            begin
                sel_slot = best;
                sel_valid = 1'b1;
            end
            if (!sel_valid || sel_slot != p.slot)
            begin
                r.action = ACT_NOT_SELECTED;
            end
            else
            begin
                if (mode == PKT_MODE_SRV && p.origin[63:32] != 32'd0
                    && p.receive[63:32] != 32'd0)
                begin
                    d1 = p.receive - p.origin;
                    d2 = p.transmit - p.arrival;
                    offset = {d1[63], d1[63:1]} + {d2[63], d2[63:1]};
                end
                else
                begin
                    offset = p.transmit - p.arrival;
                end
                so = longint'(offset);
                lim = longint'({33'd0, max_slew});
                r.clock_offset = offset;
                if (so < lim && so > -lim)
                begin
                    r.action = ACT_SLEW;
                    r.slew_fraction = offset[31:0];
                end
                else
                begin
                    r.action = ACT_STEP;
                    r.step_time = p.transmit;
                end
            end
        end
        r.selected_slot = sel_slot;
        r.selected_valid = sel_valid;
        return r;
    endfunction

    function automatic logic [7:0] lvm_of(input logic [1:0] leap, input logic [2:0] ver,
                                          input logic [2:0] mode);
        return {leap, ver, mode};
    endfunction

    function automatic ntp_pkt_t pkt_of(input slot_t slot, input logic [15:0] length,
                                        input logic [7:0] lvm, input logic [7:0] stratum,
                                        input logic [63:0] origin, input logic [63:0] receive,
                                        input logic [63:0] transmit,
                                        input logic [63:0] arrival);
        ntp_pkt_t p;
        p.slot = slot;
        p.length = length;
        p.lvm = lvm;
        p.stratum = stratum;
        p.origin = origin;
        p.receive = receive;
        p.transmit = transmit;
        p.arrival = arrival;
        return p;
    endfunction

    function automatic sync_result_t res_of(input action_t action, input slot_t slot,
                                            input logic valid);
        sync_result_t r;
        r.action = action;
        r.slew_fraction = '0;
        r.step_time = '0;
        r.clock_offset = '0;
        r.selected_slot = slot;
        r.selected_valid = valid;
        return r;
    endfunction

    function automatic logic [63:0] rand_delta();
        logic [31:0] r;
        logic [63:0] d;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: d = {{36{r[27]}}, r[27:0]};
            4, 5, 6: d = {{32{r[31]}}, r};
            7:
            begin
                d = {33'd0, max_slew} + 64'($urandom_range(0, 2)) - 64'd1;
                if (r[0])
                begin
                    d = -d;
                end
            end
            default: d = {$urandom, r};
        endcase
        return d;
    endfunction

    function automatic ntp_pkt_t random_packet();
        ntp_pkt_t p;
        int k;
        logic [1:0] leap;
        logic [2:0] ver;
        logic [2:0] mode;
        if ($urandom_range(0, 99) < 12)
        begin
            p.slot = slot_t'($urandom);
            p.length = 16'($urandom);
            p.lvm = 8'($urandom);
            p.stratum = 8'($urandom);
            p.origin = {$urandom, $urandom};
            p.receive = {$urandom, $urandom};
            p.transmit = {$urandom, $urandom};
            p.arrival = {$urandom, $urandom};
            return p;
        end
        k = $urandom_range(0, 99);
        if (k < 80)
        begin
            wall_sec = wall_sec + $urandom_range(0, 3);
        end
        else if (k < 92)
        begin
            wall_sec = wall_sec + dead_timeout + $urandom_range(0, 2);
        end
        else
        begin
            wall_sec = $urandom;
        end
        if (sel_valid && $urandom_range(0, 99) < 45)
        begin
            p.slot = sel_slot;
        end
        else
        begin
            p.slot = slot_t'($urandom);
        end
        k = $urandom_range(0, 99);
        if (k < 3)
        begin
            p.length = 16'($urandom_range(0, 47));
        end
        else if (k < 90)
        begin
            p.length = 16'($urandom_range(48, 1500));
        end
        else
        begin
            p.length = 16'($urandom_range(48, 65535));
        end
        leap = ($urandom_range(0, 99) < 4) ? LEAP_ALARM : 2'($urandom_range(0, 2));
        ver = ($urandom_range(0, 99) < 3) ? 3'($urandom) : 3'($urandom_range(1, 3));
        k = $urandom_range(0, 99);
        if (k < 80)
        begin
            mode = PKT_MODE_SRV;
        end
        else if (k < 95)
        begin
            mode = PKT_MODE_BCAST;
        end
        else
        begin
            mode = 3'($urandom);
        end
        p.lvm = lvm_of(leap, ver, mode);
        p.stratum = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        p.arrival = {wall_sec, $urandom};
        p.transmit = p.arrival + rand_delta();
        k = $urandom_range(0, 99);
        if (k < 20)
        begin
            p.origin = '0;
        end
        else if (k < 25)
        begin
            p.origin = {32'd0, $urandom};
        end
        else
        begin
            p.origin = p.arrival - {30'd0, 2'($urandom_range(0, 2)), $urandom};
        end
        if ($urandom_range(0, 99) < 5)
        begin
            p.receive = {32'd0, $urandom};
        end
        else
        begin
            p.receive = p.origin + rand_delta();
        end
        return p;
    endfunction

    function automatic int pick_gap();
        int k;
        if (calm)
        begin
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 60)
        begin
            return 0;
        end
        else if (k < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch on result %0d, %s: got %h, expected %h",
                 results_seen, field, got, want);
    endtask

    task automatic send_packet(input ntp_pkt_t p, input int gap, input bit typed,
                               input sync_result_t want);
        sync_result_t predicted;
        if (gap > 0)
        begin
            pkt_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_bus.valid <= 1'b1;
        pkt_bus.server_slot <= p.slot;
        pkt_bus.packet_length <= p.length;
        pkt_bus.leap_version_mode <= p.lvm;
        pkt_bus.peer_stratum <= p.stratum;
        pkt_bus.origin_stamp <= p.origin;
        pkt_bus.receive_stamp <= p.receive;
        pkt_bus.transmit_stamp <= p.transmit;
        pkt_bus.arrival_stamp <= p.arrival;
        @(posedge clk);
        while (!pkt_bus.ready)
        begin
            @(posedge clk);
        end
        predicted = predict_sync(p);
        sync_expect_q.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_BROADCAST_ENABLE: bcast_en = value[0];
            CFG_CONFIGURED_MASK: cfg_mask = value[7:0];
            CFG_DEAD_TIMEOUT: dead_timeout = value;
            CFG_MAX_SLEW: max_slew = value[30:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (sync_expect_q.size() == 0)
            begin
                report_mismatch("unexpected result, action", 64'(res_bus.action), '0);
            end
            else
            begin
                head = sync_expect_q.pop_front();
                if (res_bus.action !== head.action)
                    report_mismatch("action", 64'(res_bus.action), 64'(head.action));
                if (res_bus.slew_fraction !== head.slew_fraction)
                    report_mismatch("slew_fraction", 64'(res_bus.slew_fraction),
                                    64'(head.slew_fraction));
                if (res_bus.step_time !== head.step_time)
                    report_mismatch("step_time", res_bus.step_time, head.step_time);
                if (res_bus.clock_offset !== head.clock_offset)
                    report_mismatch("clock_offset", res_bus.clock_offset, head.clock_offset);
                if (res_bus.selected_slot !== head.selected_slot)
                    report_mismatch("selected_slot", 64'(res_bus.selected_slot),
                                    64'(head.selected_slot));
                if (res_bus.selected_valid !== head.selected_valid)
                    report_mismatch("selected_valid", 64'(res_bus.selected_valid),
                                    64'(head.selected_valid));
            end
            results_seen++;
        end
    end

    // The result side: random stalls, plus two long holds that back the block up.
    initial
    begin
        int stall_left;
        int backlog_holds;
        stall_left = 0;
        backlog_holds = 0;
        res_bus.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (backlog_holds < 2 && results_seen >= 150 + 300 * backlog_holds)
            begin
                backlog_holds++;
                res_bus.ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(negedge clk);
            end
            else if (calm)
            begin
                res_bus.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                res_bus.ready <= 1'b1;
            end
            else
            begin
                res_bus.ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                         : $urandom_range(10, 40);
            end
        end
    end

    initial
    begin
        dir_row_t     directed_rows [$];
        sync_result_t no_check;
        logic [63:0]  good_lvm;
        pkt_bus.valid <= 1'b0;
        pkt_bus.server_slot <= '0;
        pkt_bus.packet_length <= '0;
        pkt_bus.leap_version_mode <= '0;
        pkt_bus.peer_stratum <= '0;
        pkt_bus.origin_stamp <= '0;
        pkt_bus.receive_stamp <= '0;
        pkt_bus.transmit_stamp <= '0;
        pkt_bus.arrival_stamp <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_BROADCAST_ENABLE;
        cfg_bus.data <= '0;
        wall_sec = $urandom;
        no_check = res_of(ACT_DROP, '0, 1'b0);
        good_lvm = 64'(lvm_of(LEAP_NONE, VERSION_MAX, PKT_MODE_SRV));

        directed_rows.push_back('{pkt_of(3'd0, 16'd0, good_lvm[7:0], 8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd0, 16'd47, good_lvm[7:0], 8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd0, 16'hFFFF,
                                         lvm_of(LEAP_NONE, VERSION_ZERO, PKT_MODE_SRV),
                                         8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd1, 16'd48,
                                         lvm_of(LEAP_NONE, VERSION_FOUR, PKT_MODE_SRV),
                                         8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd1, 16'd48, 8'hFF, 8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd7, 16'd48,
                                         lvm_of(LEAP_ALARM, VERSION_MIN, PKT_MODE_SRV),
                                         8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_UNSYNC, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd2, 16'd48,
                                         lvm_of(LEAP_NONE, VERSION_MAX, PKT_MODE_CLI),
                                         8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd2, 16'd48,
                                         lvm_of(LEAP_NONE, VERSION_MAX, PKT_MODE_BCAST),
                                         8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd2, 16'd48, good_lvm[7:0], 8'd1, '0, '0,
                                         64'h0000_0000_FFFF_FFFF, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd2, 16'd48, 8'h00, 8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_DROP, 3'd0, 1'b0)});
        directed_rows.push_back('{pkt_of(3'd2, 16'd48, good_lvm[7:0], 8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_SLEW, 3'd2, 1'b1)});
        directed_rows.push_back('{pkt_of(3'd0, 16'd48, good_lvm[7:0], 8'd1, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_NOT_SELECTED, 3'd2, 1'b1)});
        directed_rows.push_back('{pkt_of(3'd5, 16'd48, good_lvm[7:0], 8'd0, T0 - ONE_SEC,
                                         T0 - ONE_SEC + 64'h0100_0000, T0 + 64'h0200_0000,
                                         T0 + 64'h0080_0000),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd5, 16'd48, good_lvm[7:0], 8'd0, '0, '0,
                                         T0 + 64'h1000_0000, T0),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd5, 16'd48, good_lvm[7:0], 8'd0, '0, '0,
                                         T0, T0 + 64'h0FFF_FFFF),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd5, 16'd48, good_lvm[7:0], 8'd0, '0, '0,
                                         T0, T0 + 64'h1000_0000),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd5, 16'd48,
                                         lvm_of(LEAP_ALARM, VERSION_MAX, PKT_MODE_SRV),
                                         8'd0, '0, '0, T0, T0),
                                  1'b1, res_of(ACT_UNSYNC, 3'd5, 1'b1)});
        directed_rows.push_back('{pkt_of(3'd0, 16'd48, good_lvm[7:0], 8'd1, T0, T0, T0,
                                         T0 + 64'h0000_0000_0000_0001),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd7, 16'd48,
                                         lvm_of(LEAP_NONE, VERSION_MIN, PKT_MODE_SRV),
                                         8'd255, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd1, 16'd48, good_lvm[7:0], 8'd2, T0,
                                         T0 + 64'h2000, T0 + ONE_SEC,
                                         T0 + ONE_SEC + 64'h1000),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd3, 16'd48,
                                         lvm_of(LEAP_MINUS, 3'd2, PKT_MODE_SRV),
                                         8'd0, '0, '0, ONE_SEC, '0),
                                  1'b0, no_check});
        directed_rows.push_back('{pkt_of(3'd4, 16'd48,
                                         lvm_of(LEAP_NONE, VERSION_MAX, PKT_MODE_BCAST),
                                         8'd0, '0, '0, ONE_SEC, '0),
                                  1'b1, res_of(ACT_DROP, 3'd3, 1'b1)});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_packet(directed_rows[i].p, pick_gap(), directed_rows[i].typed,
                        directed_rows[i].want);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            pkt_bus.valid <= 1'b0;
            while (sync_expect_q.size() != 0)
            begin
                @(negedge clk);
            end
            case (phase)
                0:
                begin
                    write_register(CFG_BROADCAST_ENABLE, 32'hFFFF_FFFF);
                    write_register(CFG_CONFIGURED_MASK, 32'hFFFF_FFFF);
                    write_register(CFG_DEAD_TIMEOUT, 32'hFFFF_FFFF);
                    write_register(CFG_MAX_SLEW, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_register(CFG_BROADCAST_ENABLE, 32'd0);
                    write_register(CFG_CONFIGURED_MASK, 32'd0);
                    write_register(CFG_DEAD_TIMEOUT, 32'd0);
                    write_register(CFG_MAX_SLEW, 32'd0);
                end
                2:
                begin
                    write_register(CFG_BROADCAST_ENABLE, 32'd1);
                    write_register(CFG_CONFIGURED_MASK, $urandom);
                    write_register(CFG_DEAD_TIMEOUT, $urandom_range(2, 12));
                    write_register(CFG_MAX_SLEW, $urandom & 32'h0FFF_FFFF);
                end
                3:
                begin
                    write_register(CFG_BROADCAST_ENABLE, $urandom);
                    write_register(CFG_CONFIGURED_MASK, $urandom);
                    write_register(CFG_DEAD_TIMEOUT, 32'd3600);
                    write_register(CFG_MAX_SLEW, $urandom_range(0, 32'h4000_0000));
                end
                4:
                begin
                    write_register(CFG_BROADCAST_ENABLE, 32'd0);
                    write_register(CFG_CONFIGURED_MASK, $urandom);
                    write_register(CFG_DEAD_TIMEOUT, $urandom);
                    write_register(CFG_MAX_SLEW, $urandom);
                end
                default:
                begin
                    write_register(CFG_BROADCAST_ENABLE, 32'd1);
                    write_register(CFG_CONFIGURED_MASK, 32'h0000_0055);
                    write_register(CFG_DEAD_TIMEOUT, 32'd1);
                    write_register(CFG_MAX_SLEW, 32'h1000_0000);
                end
            endcase
            cfg_bus.valid <= 1'b0;
            calm = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_packet(random_packet(), pick_gap(), 1'b0, no_check);
            end
        end

        pkt_bus.valid <= 1'b0;
        while (sync_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SLOTS + 16) @(negedge clk);
        if (mismatch_count == 0 && sync_expect_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
